// File: hw/rtl/bdpp_pkg.sv
// ---------------------------------------------------------------------------
// bdpp_pkg - shared types and constants of the box downsample pixel packer
// Sizes, channel layout, register indexes and the divide-by-255 helpers.
// ---------------------------------------------------------------------------
package bdpp_pkg;

  // Configuration limits
  localparam int MAX_SOURCE_SIZE = 1024;
  localparam int MAX_RATIO_LOG2  = 4;

  // Derived widths
  localparam int POS_W  = $clog2(MAX_SOURCE_SIZE);
  localparam int SIZE_W = $clog2(MAX_SOURCE_SIZE + 1);
  localparam int K_W    = $clog2(MAX_RATIO_LOG2 + 1);
  localparam int RM_W   = MAX_RATIO_LOG2;

  // Fixed field widths
  localparam int CH_W       = 8;
  localparam int SUM_W      = 16;
  localparam int MASK_W     = 16;
  localparam int DEST_W     = 10;
  localparam int SRC_SIZE_W = 11;
  localparam int RATIO_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = CH_W + MASK_W;
  localparam int QUO_W      = PROD_W - CH_W + 1;
  localparam int ACC_W      = PROD_W + 25;
  localparam int DIV_CONST  = 255;

  // Channel lanes
  localparam int NCH      = 4;
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int CH_ALPHA = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_SIZE   = 3'd0,
    CFG_RATIO_LOG2    = 3'd1,
    CFG_BLUE_MASK     = 3'd2,
    CFG_GREEN_MASK    = 3'd3,
    CFG_RED_MASK      = 3'd4,
    CFG_ALPHA_MASK    = 3'd5,
    CFG_ALPHA_PRESENT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] alpha_in;
  } texel_t;

  typedef struct packed {
    logic [MASK_W-1:0] pixel_word;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic              frame_last;
  } pixel_t;

  typedef logic [NCH-1:0][SUM_W-1:0]  sums_t;
  typedef logic [NCH-1:0][CH_W-1:0]   chans_t;
  typedef logic [NCH-1:0][MASK_W-1:0] masks_t;
  typedef logic [NCH-1:0][PROD_W-1:0] prods_t;
  typedef logic [NCH-1:0][QUO_W-1:0]  quos_t;

  // Block position of a transaction in the line-store stage
  typedef struct packed {
    logic [POS_W-1:0] idx;
    logic             start;
    logic             done;
    chans_t           chans;
    logic [POS_W-1:0] dy;
    logic             last;
  } acc_info_t;

  // Tag that follows a finished block through the scaling stages
  typedef struct packed {
    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] dy;
    logic             last;
  } tag_t;

  // Estimate floor(x / 255) as (x * 0x01010101) >> 32; low by at most one
  function automatic logic [QUO_W-1:0] div255_est(input logic [PROD_W-1:0] x);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(x) + (ACC_W'(x) << 8) + (ACC_W'(x) << 16) + (ACC_W'(x) << 24);
    return acc[ACC_W-1 -: QUO_W];
  endfunction

  // Fix up the estimate with one compare of the remainder
  function automatic logic [QUO_W-1:0] div255_fix(input logic [PROD_W-1:0] x,
                                                  input logic [QUO_W-1:0]  q);
    logic [PROD_W:0] q255;
    logic [PROD_W:0] rem;
    q255 = ((PROD_W + 1)'(q) << 8) - (PROD_W + 1)'(q);
    rem  = (PROD_W + 1)'(x) - q255;
    return (rem >= (PROD_W + 1)'(DIV_CONST)) ? q + 1'b1 : q;
  endfunction

endpackage

// File: hw/rtl/bdpp_ram.sv
// ---------------------------------------------------------------------------
// bdpp_ram - generic simple dual-port RAM
// One write port, one read port, registered read data (read-old on collision).
// ---------------------------------------------------------------------------
module bdpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/box_downsample_pixel_pack_core.sv
// ---------------------------------------------------------------------------
// box_downsample_pixel_pack_core - box-filter downsampler, 16-bit pixel packer
// Sums each ratio-by-ratio block of raster-order texels in a column line
// store, averages by shift, scales each channel into its mask and packs.
// ---------------------------------------------------------------------------
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------
//   texel    | in        | texel_valid / texel_ready | texel (blue,green,red,a)
//   pixel    | out       | pixel_valid / pixel_ready | pixel (word, x, y, last)
//   cfg      | in        | cfg_we (no wait)          | cfg_index, cfg_data
//
// One texel per cycle unless texel_ready is low: each texel does one
// read-modify-write of the line store (registered read, write back from the
// next stage, bypass from the last write). Stages after a block's last texel:
// store update with average, channel multiply, divide estimate, fixup/pack.
// Reset restores the register defaults and the raster position; the line
// store is not cleared, every block overwrites its entry on its first texel.
// Output stalls back up through the scaling stages; texels keep flowing
// until a block-completing texel finds no room behind the store stage.
// ---------------------------------------------------------------------------
module box_downsample_pixel_pack_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bdpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdpp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               texel_valid,
  output logic                               texel_ready,
  input  bdpp_pkg::texel_t                   texel,
  output logic                               pixel_valid,
  input  logic                               pixel_ready,
  output bdpp_pkg::pixel_t                   pixel
);
  import bdpp_pkg::*;

  // Configuration registers
  logic [SRC_SIZE_W-1:0] source_size;
  logic [RATIO_W-1:0]    ratio_log2;
  logic [MASK_W-1:0]     blue_mask;
  logic [MASK_W-1:0]     green_mask;
  logic [MASK_W-1:0]     red_mask;
  logic [MASK_W-1:0]     alpha_mask;
  logic                  alpha_present;
  logic                  cfg_hit;

  // Raster position
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  col_next;
  logic [POS_W-1:0]  row_next;

  // Front-end decode
  logic [SIZE_W-1:0] size_eff;
  logic [K_W-1:0]    k;
  logic [RM_W-1:0]   rmask;
  logic [POS_W-1:0]  rmask_pos;
  logic [POS_W-1:0]  col_m;
  logic [POS_W-1:0]  row_m;
  logic [POS_W-1:0]  dx;
  logic [POS_W-1:0]  dy;
  logic [SIZE_W-1:0] last_blk;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              accept;
  acc_info_t         front;

  // Line-store stage
  logic              p1_valid;
  acc_info_t         p1;
  logic              p1_adv;
  logic [POS_W-1:0]  raddr;
  sums_t             rdata;
  sums_t             old_sums;
  sums_t             new_sums;
  logic              mem_we;
  logic              fwd_valid;
  logic [POS_W-1:0]  fwd_idx;
  sums_t             fwd_data;
  logic [K_W:0]      shamt;

  // Scaling stages
  logic              p2_valid;
  logic              p2_load;
  chans_t            p2_avg;
  tag_t              p2_tag;
  logic              p3_valid;
  logic              p3_load;
  prods_t            p3_prod;
  tag_t              p3_tag;
  logic              p4_valid;
  logic              p4_load;
  prods_t            p4_prod;
  quos_t             p4_quo;
  tag_t              p4_tag;
  logic              out_load;
  masks_t            masks;
  logic [MASK_W-1:0] word_next;

  // Hold register writes
  assign cfg_hit = cfg_we && (cfg_index <= CFG_ALPHA_PRESENT);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_size   <= SRC_SIZE_W'(256);
      ratio_log2    <= RATIO_W'(1);
      blue_mask     <= MASK_W'(31);
      green_mask    <= MASK_W'(2016);
      red_mask      <= MASK_W'(63488);
      alpha_mask    <= '0;
      alpha_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_SIZE:   source_size   <= cfg_data[SRC_SIZE_W-1:0];
        CFG_RATIO_LOG2:    ratio_log2    <= cfg_data[RATIO_W-1:0];
        CFG_BLUE_MASK:     blue_mask     <= cfg_data;
        CFG_GREEN_MASK:    green_mask    <= cfg_data;
        CFG_RED_MASK:      red_mask      <= cfg_data;
        CFG_ALPHA_MASK:    alpha_mask    <= cfg_data;
        CFG_ALPHA_PRESENT: alpha_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp size and ratio
  always_comb begin
    if (source_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (32'(source_size) > MAX_SOURCE_SIZE) begin
      size_eff = SIZE_W'(MAX_SOURCE_SIZE);
    end else begin
      size_eff = SIZE_W'(source_size);
    end
    if (32'(ratio_log2) > MAX_RATIO_LOG2) begin
      k = K_W'(MAX_RATIO_LOG2);
    end else begin
      k = K_W'(ratio_log2);
    end
  end

  // Decode block position of the incoming texel
  always_comb begin
    rmask     = ~({RM_W{1'b1}} << k);
    rmask_pos = POS_W'(rmask);
    col_m     = col & rmask_pos;
    row_m     = row & rmask_pos;
    dx        = col >> k;
    dy        = row >> k;
    last_blk  = (size_eff >> k) - 1'b1;

    front.idx   = dx;
    front.start = (col_m == '0) && (row_m == '0);
    front.done  = (col_m == rmask_pos) && (row_m == rmask_pos);
    front.dy    = dy;
    front.last  = (SIZE_W'(dx) == last_blk) && (SIZE_W'(dy) == last_blk);
    front.chans[CH_BLUE]  = texel.blue_in;
    front.chans[CH_GREEN] = texel.green_in;
    front.chans[CH_RED]   = texel.red_in;
    front.chans[CH_ALPHA] = alpha_present ? texel.alpha_in : '0;
  end

  // Advance raster position
  always_comb begin
    col_inc  = SIZE_W'(col) + 1'b1;
    row_inc  = SIZE_W'(row) + 1'b1;
    col_next = col_inc[POS_W-1:0];
    row_next = row;
    if (col_inc >= size_eff) begin
      col_next = '0;
      row_next = (row_inc >= size_eff) ? '0 : row_inc[POS_W-1:0];
    end
  end

  assign accept = texel_valid && texel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Stage flow control, back to front
  assign out_load    = !pixel_valid || pixel_ready;
  assign p4_load     = !p4_valid || out_load;
  assign p3_load     = !p3_valid || p4_load;
  assign p2_load     = !p2_valid || p3_load;
  assign p1_adv      = !p1_valid || !p1.done || p2_load;
  assign texel_ready = p1_adv;

  // Line store: read at accept, write back from the next stage
  assign raddr  = p1_adv ? front.idx : p1.idx;
  assign mem_we = p1_valid && p1_adv;

  bdpp_ram #(
    .WIDTH ($bits(sums_t)),
    .DEPTH (MAX_SOURCE_SIZE)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (p1.idx),
    .wdata (new_sums),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Bypass the write that collided with this read, then accumulate
  always_comb begin
    old_sums = (fwd_valid && (fwd_idx == p1.idx)) ? fwd_data : rdata;
    for (int i = 0; i < NCH; i++) begin
      if (p1.start) begin
        new_sums[i] = SUM_W'(p1.chans[i]);
      end else begin
        new_sums[i] = old_sums[i] + SUM_W'(p1.chans[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (p1_adv) begin
        p1_valid <= accept;
      end
      if (mem_we) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p1 <= front;
    end
    if (mem_we) begin
      fwd_idx  <= p1.idx;
      fwd_data <= new_sums;
    end
  end

  // Average: shift the block sum by twice the ratio log
  assign shamt = {k, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_load) begin
      p2_valid <= p1_valid && p1.done;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_load) begin
      for (int i = 0; i < NCH; i++) begin
        p2_avg[i] <= CH_W'(new_sums[i] >> shamt);
      end
      p2_tag.dx   <= p1.idx;
      p2_tag.dy   <= p1.dy;
      p2_tag.last <= p1.last;
    end
  end

  // Scale by each channel mask
  always_comb begin
    masks[CH_BLUE]  = blue_mask;
    masks[CH_GREEN] = green_mask;
    masks[CH_RED]   = red_mask;
    masks[CH_ALPHA] = alpha_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (p3_load) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_load) begin
      for (int i = 0; i < NCH; i++) begin
        p3_prod[i] <= PROD_W'(p2_avg[i]) * PROD_W'(masks[i]);
      end
      p3_tag <= p2_tag;
    end
  end

  // Estimate the divide by 255
  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (p4_load) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p4_load) begin
      for (int i = 0; i < NCH; i++) begin
        p4_quo[i] <= div255_est(p3_prod[i]);
      end
      p4_prod <= p3_prod;
      p4_tag  <= p3_tag;
    end
  end

  // Correct the quotient, mask and pack
  always_comb begin
    word_next = '0;
    for (int i = 0; i < NCH; i++) begin
      word_next = word_next | (MASK_W'(div255_fix(p4_prod[i], p4_quo[i])) & masks[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (out_load) begin
      pixel_valid <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel.pixel_word <= word_next;
      pixel.dest_x     <= DEST_W'(p4_tag.dx);
      pixel.dest_y     <= DEST_W'(p4_tag.dy);
      pixel.frame_last <= p4_tag.last;
    end
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench of the box downsample pixel packer
// Streams texels through the core under several register settings and checks
// every packed pixel against typed answers or a box-average predictor kept in
// the bench. A short table covers the corners first. Random blocks, random
// masks and random back-pressure on both channels follow.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdpp_pkg::*;

  localparam int RANDOM_TEXELS = 1330;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_BURST     = 300;
  localparam int unsigned SEND_IDLE_PCT [3] = '{13, 52, 0};
  localparam int unsigned RECV_IDLE_PCT [3] = '{52, 13, 0};

  typedef enum logic {ROW_WRITE, ROW_TEXEL} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    cfg_reg_t                cfg_sel;
    logic [CFG_DATA_W-1:0]   value;
    texel_t                  tx;
    logic                    fixed;
    pixel_t                  want;
  } dir_row_t;

  localparam texel_t NO_TEXEL = '0;
  localparam texel_t WHITE    = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
  localparam pixel_t NO_PIXEL = '0;
  localparam int DIR_ROWS = 38;

  // Corner cases with the obvious answers typed in; the rest use the predictor
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // 2x2 image, reset ratio and 565 masks: white, then black
    '{ROW_WRITE, CFG_SOURCE_SIZE, 16'd2, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, WHITE, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, WHITE, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, WHITE, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, WHITE, 1'b1, '{16'hFFFF, 10'd0, 10'd0, 1'b1}},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, NO_TEXEL, 1'b1, '{16'h0000, 10'd0, 10'd0, 1'b1}},
    // block larger than the image: nothing comes out
    '{ROW_WRITE, CFG_SOURCE_SIZE, 16'd1, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, WHITE, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, WHITE, 1'b0, NO_PIXEL},
    // zero size acts as one texel, ratio 1:1, alpha on full mask
    '{ROW_WRITE, CFG_RATIO_LOG2, 16'd0, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_SOURCE_SIZE, 16'd0, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_ALPHA_PRESENT, 16'd1, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_ALPHA_MASK, 16'hFFFF, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd255},
      1'b1, '{16'hFFFF, 10'd0, 10'd0, 1'b1}},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd128},
      1'b1, '{16'h8080, 10'd0, 10'd0, 1'b1}},
    // alpha off: the alpha input is ignored
    '{ROW_WRITE, CFG_ALPHA_PRESENT, 16'd0, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd255},
      1'b1, '{16'h0000, 10'd0, 10'd0, 1'b1}},
    // full blue mask, empty green and red masks
    '{ROW_WRITE, CFG_BLUE_MASK, 16'hFFFF, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_GREEN_MASK, 16'h0000, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_RED_MASK, 16'h0000, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd1, 8'd255, 8'd255, 8'd0},
      1'b1, '{16'h0101, 10'd0, 10'd0, 1'b1}},
    // 3x3 image with 2x2 blocks: partial blocks at the right and bottom
    '{ROW_WRITE, CFG_RATIO_LOG2, 16'd1, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_SOURCE_SIZE, 16'd3, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_BLUE_MASK, 16'h001F, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_GREEN_MASK, 16'h07E0, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_WRITE, CFG_RED_MASK, 16'hF800, NO_TEXEL, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd10, 8'd20, 8'd30, 8'd40}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd200, 8'd100, 8'd50, 8'd0}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd7, 8'd7, 8'd7, 8'd7}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd255, 8'd0, 8'd128, 8'd1}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd1, 8'd2, 8'd3, 8'd4}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd90, 8'd180, 8'd45, 8'd9}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd33, 8'd66, 8'd99, 8'd132}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd128, 8'd127, 8'd64, 8'd63}, 1'b0, NO_PIXEL},
    '{ROW_TEXEL, CFG_SOURCE_SIZE, 16'd0, '{8'd254, 8'd1, 8'd253, 8'd2}, 1'b0, NO_PIXEL}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  texel_valid;
  logic                  texel_ready;
  texel_t                texel;
  logic                  pixel_valid;
  logic                  pixel_ready;
  pixel_t                pixel;

  // Bench copy of the registers, reset values
  logic [SRC_SIZE_W-1:0] cfg_size     = 11'd256;
  logic [RATIO_W-1:0]    cfg_ratio    = 3'd1;
  logic [MASK_W-1:0]     cfg_mask [NCH] = '{16'd31, 16'd2016, 16'd63488, 16'd0};
  logic                  cfg_alpha_on = 1'b0;

  // Bench copy of the line store and raster position
  logic [SUM_W-1:0] column_sum [NCH][MAX_SOURCE_SIZE];
  int unsigned      raster_col = 0;
  int unsigned      raster_row = 0;

  pixel_t pending_pixels [$];
  int     error_count    = 0;
  int     texels_sent    = 0;
  int     pixels_checked = 0;
  int     quiet_cycles   = 0;
  int     setting_no     = 0;
  int     idle_phase     = 0;
  bit     stream_dirty   = 1'b0;
  bit     hold_pixels    = 1'b0;

  box_downsample_pixel_pack_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .texel_valid (texel_valid),
    .texel_ready (texel_ready),
    .texel       (texel),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  always #2 clk = ~clk;

  // Average of one channel, scaled into its mask
  function automatic logic [MASK_W-1:0] scale_channel(input logic [SUM_W-1:0] sum,
                                                      input int unsigned k,
                                                      input logic [MASK_W-1:0] mask);
    int unsigned avg;
    avg = (sum >> (2 * k)) & 32'hFF;
    return MASK_W'((avg * mask) / 255) & mask;
  endfunction

  // Accumulate one texel into its block; returns 1 with the pixel when the
  // block completes
  function automatic bit box_average_pixel(input texel_t t, output pixel_t p);
    int unsigned     size, k, rmask, idx, last_blk;
    logic [CH_W-1:0] level [NCH];
    logic [MASK_W-1:0] word;
    bit              first, fin;
    size = (cfg_size == 0) ? 1 :
           (cfg_size > MAX_SOURCE_SIZE) ? MAX_SOURCE_SIZE : cfg_size;
    k = (cfg_ratio > MAX_RATIO_LOG2) ? MAX_RATIO_LOG2 : cfg_ratio;
    rmask = (1 << k) - 1;
    if (raster_col >= size) raster_col = 0;
    if (raster_row >= size) raster_row = 0;
    idx = (raster_col >> k) % MAX_SOURCE_SIZE;
    level[CH_BLUE]  = t.blue_in;
    level[CH_GREEN] = t.green_in;
    level[CH_RED]   = t.red_in;
    level[CH_ALPHA] = cfg_alpha_on ? t.alpha_in : '0;
    first = ((raster_row & rmask) == 0) && ((raster_col & rmask) == 0);
    fin   = ((raster_row & rmask) == rmask) && ((raster_col & rmask) == rmask);
    // overwrite on the block's first texel, add (16-bit wrap) otherwise
    word = '0;
    for (int c = 0; c < NCH; c++) begin
      column_sum[c][idx] = first ? SUM_W'(level[c]) : column_sum[c][idx] + SUM_W'(level[c]);
      word |= scale_channel(column_sum[c][idx], k, cfg_mask[c]);
    end
    p = '0;
    if (fin) begin
      last_blk = (size >> k) - 1;
      p.pixel_word = word;
      p.dest_x     = DEST_W'(raster_col >> k);
      p.dest_y     = DEST_W'(raster_row >> k);
      p.frame_last = ((raster_col >> k) == last_blk) && ((raster_row >> k) == last_blk);
    end
    // advance the raster position, wrap at frame end
    raster_col++;
    if (raster_col >= size) begin
      raster_col = 0;
      raster_row++;
      if (raster_row >= size) raster_row = 0;
    end
    return fin;
  endfunction

  function automatic logic [CH_W-1:0] random_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return '0;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // Drop valid, wait for every pixel, then let the pipeline empty
  task automatic settle_stream();
    @(negedge clk);
    texel_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    stream_dirty = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    if (stream_dirty) settle_stream();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (sel)
      CFG_SOURCE_SIZE:   cfg_size = value[SRC_SIZE_W-1:0];
      CFG_RATIO_LOG2:    cfg_ratio = value[RATIO_W-1:0];
      CFG_BLUE_MASK:     cfg_mask[CH_BLUE] = value;
      CFG_GREEN_MASK:    cfg_mask[CH_GREEN] = value;
      CFG_RED_MASK:      cfg_mask[CH_RED] = value;
      CFG_ALPHA_MASK:    cfg_mask[CH_ALPHA] = value;
      CFG_ALPHA_PRESENT: cfg_alpha_on = value[0];
      default: ;
    endcase
    // any write restarts the frame
    raster_col = 0;
    raster_row = 0;
  endtask

  // Offer one texel, hold it until taken, then record the pixel it yields
  task automatic send_texel(input texel_t t, input bit fixed, input pixel_t fixed_pix);
    pixel_t p;
    bit     got;
    @(negedge clk);
    while ($urandom_range(99) < SEND_IDLE_PCT[idle_phase]) begin
      texel_valid = 1'b0;
      @(negedge clk);
    end
    texel_valid = 1'b1;
    texel       = t;
    do @(posedge clk); while (!texel_ready);
    texels_sent++;
    stream_dirty = 1'b1;
    got = box_average_pixel(t, p);
    if (fixed) pending_pixels.push_back(fixed_pix);
    else if (got) pending_pixels.push_back(p);
  endtask

  // Pixel receiver: random stalls, plus one long hold on request
  initial begin : pixel_sink
    pixel_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pixels) begin
        hold_pixels = 1'b0;
        pixel_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        pixel_ready = ($urandom_range(99) >= RECV_IDLE_PCT[idle_phase]);
      end
    end
  end

  // Check each pixel transaction; watch for a stuck stream
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (pixel_valid && pixel_ready) begin
      if (pending_pixels.size() == 0) begin
        error_count++;
        $display("%0t: pixel mismatch, expected none, got %h", $time, pixel);
      end else begin
        want = pending_pixels.pop_front();
        compare_field("pixel_word", want.pixel_word, pixel.pixel_word);
        compare_field("dest_x", 16'(want.dest_x), 16'(pixel.dest_x));
        compare_field("dest_y", 16'(want.dest_y), 16'(pixel.dest_y));
        compare_field("frame_last", 16'(want.frame_last), 16'(pixel.frame_last));
        pixels_checked++;
      end
    end
    if ((texel_valid && texel_ready) || (pixel_valid && pixel_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    texel_t      tx;
    int unsigned random_texels, n, kk, rsel, size_val, ratio_val, eff, blocks;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    texel_valid = 1'b0;
    texel       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_WRITE) write_reg(DIR_TABLE[i].cfg_sel, DIR_TABLE[i].value);
      else send_texel(DIR_TABLE[i].tx, DIR_TABLE[i].fixed, DIR_TABLE[i].want);
    end

    // Random settings, each followed by a burst of random texels
    random_texels = 0;
    while (random_texels < RANDOM_TEXELS) begin
      rsel = $urandom_range(0, 19);
      kk = (rsel < 6) ? 0 : (rsel < 12) ? 1 : (rsel < 16) ? 2 : (rsel < 18) ? 3 : 4;
      ratio_val = (rsel == 19) ? $urandom_range(5, 7) : kk;
      blocks = $urandom_range(1, (kk <= 1) ? 8 : (kk == 2) ? 3 : 1);
      size_val = blocks << kk;
      if (kk > 0 && kk <= 2 && $urandom_range(0, 4) == 0)
        size_val += $urandom_range(1, (1 << kk) - 1);
      if (kk == 0 && $urandom_range(0, 9) == 0)
        size_val = $urandom_range(0, 1) ? 0 : $urandom_range(1024, 2047);
      // pin the corners on the first few settings
      case (setting_no)
        0: begin ratio_val = 0; size_val = 16; end
        1: begin ratio_val = 7; size_val = 16; end
        2: begin ratio_val = 0; size_val = 2047; end
        3: begin ratio_val = 4; size_val = 16; end
        default: ;
      endcase
      eff = (size_val == 0) ? 1 : (size_val > MAX_SOURCE_SIZE) ? MAX_SOURCE_SIZE : size_val;
      n = eff * eff * $urandom_range(1, 2);
      if (n > MAX_BURST) n = $urandom_range(MAX_BURST / 5, MAX_BURST);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (setting_no == 1 || setting_no == 3) n = 256;
      if (n > RANDOM_TEXELS - random_texels) n = RANDOM_TEXELS - random_texels;

      write_reg(CFG_SOURCE_SIZE, CFG_DATA_W'(size_val));
      write_reg(CFG_RATIO_LOG2, CFG_DATA_W'(ratio_val));
      write_reg(CFG_BLUE_MASK, random_mask());
      write_reg(CFG_GREEN_MASK, random_mask());
      write_reg(CFG_RED_MASK, random_mask());
      write_reg(CFG_ALPHA_MASK, random_mask());
      write_reg(CFG_ALPHA_PRESENT, CFG_DATA_W'($urandom_range(0, 1)));

      // one pixel per texel here, so a long hold backs the core up
      if (setting_no == 0) hold_pixels = 1'b1;
      repeat (n) begin
        idle_phase = (random_texels * 3) / RANDOM_TEXELS;
        if (idle_phase > 2) idle_phase = 2;
        tx.blue_in  = random_level();
        tx.green_in = random_level();
        tx.red_in   = random_level();
        tx.alpha_in = random_level();
        send_texel(tx, 1'b0, NO_PIXEL);
        random_texels++;
      end
      setting_no++;
    end

    settle_stream();
    $display("Sent %0d texels over %0d random register settings plus the corner table;",
             texels_sent, setting_no);
    $display("compared %0d pixels with %0d mismatches.", pixels_checked, error_count);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
